// ===== rtl/core/boxblur_pkg.sv =====
package boxblur_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int RING_W     = 2;
    localparam int RING_ROWS  = 1 << RING_W;
    localparam int ADDR_W     = RING_W + COL_W;

    // pixel and arithmetic widths
    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int NUM_CHAN   = 3;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = SUM_W + 1;
    localparam int DEN_W      = CNT_W + 1;
    localparam int STEP_W     = $clog2(NUM_W + 1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FH_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DRAIN,
        ST_DIVS,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic take;
        logic clr;
        logic issue;
        logic div_start;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pix_ready;
        logic nb_last;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    typedef logic [NUM_CHAN-1:0][NUM_W-1:0] chan_num_t;

    function automatic logic [FW_W-1:0] clamp_width(input logic [FW_W-1:0] v);
        logic [FW_W-1:0] r;
        if (v == '0)
            r = FW_W'(1);
        else if (v > FW_W'(MAX_WIDTH))
            r = FW_W'(MAX_WIDTH);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [FH_W-1:0] clamp_height(input logic [FH_W-1:0] v);
        logic [FH_W-1:0] r;
        if (v == '0)
            r = FH_W'(1);
        else if (v > FH_W'(MAX_HEIGHT))
            r = FH_W'(MAX_HEIGHT);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/core/box_blur_3x3_edge_aware_top.sv =====
// an accepted beat is first checked for a ready output; if one is ready, nine neighbor
// reads through the single read port of the line memory, a drain step, the 13-step divider
// and the load of the output register follow; in_ready is high only in the idle state
// a held output does not stall input until the next result needs the output register
// reset (rst_n low, async): counters, frame flags and size registers (640 x 480) cleared;
// line memory is not cleared, entries are used only after being written
module box_blur_3x3_edge_aware_top
    import boxblur_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input beats
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   operation,
    input  logic [PIX_W-1:0]       in_blue,
    input  logic [PIX_W-1:0]       in_green,
    input  logic [PIX_W-1:0]       in_red,
    // output beats
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIX_W-1:0]       out_blue,
    output logic [PIX_W-1:0]       out_green,
    output logic [PIX_W-1:0]       out_red,
    output logic                   frame_last,
    // register writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // commands from the sequencer, status back from the datapath
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: accept, readiness check, neighbor walk, divide, load output
    boxblur_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: four-row line memory, position counters, sums, divider, output register
    boxblur_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (operation),
        .in_blue    (in_blue),
        .in_green   (in_green),
        .in_red     (in_red),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

// ===== rtl/core/boxblur_div.sv =====
module boxblur_div
    import boxblur_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  chan_num_t         num,
    input  logic [DEN_W-1:0]  den,
    output chan_num_t         quo,
    output logic              done
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [STEP_W-1:0]                  step_reg;
    logic [DEN_W-1:0]                   den_reg;
    chan_num_t                          sh_reg;
    chan_num_t                          sh_next;
    logic [NUM_CHAN-1:0][DEN_W-1:0]     rem_reg;
    logic [NUM_CHAN-1:0][DEN_W-1:0]     rem_next;

    // one restoring step per lane per cycle
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           ge;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            trial = {rem_reg[i], sh_reg[i][NUM_W-1]};
            ge    = trial >= {1'b0, den_reg};
            if (ge)
                rem_next[i] = DEN_W'(trial - {1'b0, den_reg});
            else
                rem_next[i] = trial[DEN_W-1:0];
            sh_next[i] = {sh_reg[i][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = sh_reg;
    assign done = done_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still stepping");

endmodule

// ===== rtl/core/boxblur_dp.sv =====
module boxblur_dp
    import boxblur_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat,
    input  logic                   operation,
    input  logic [PIX_W-1:0]       in_blue,
    input  logic [PIX_W-1:0]       in_green,
    input  logic [PIX_W-1:0]       in_red,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [PIX_W-1:0]       out_blue,
    output logic [PIX_W-1:0]       out_green,
    output logic [PIX_W-1:0]       out_red,
    output logic                   frame_last,
    output logic                   out_valid,
    input  logic                   out_ready
);

    logic [RGB_W-1:0]   line_mem [0:RING_ROWS*MAX_WIDTH-1];

    logic [FW_W-1:0]    fw_cfg_reg;
    logic [FH_W-1:0]    fh_cfg_reg;
    logic [FW_W-1:0]    act_w_reg;
    logic [FH_W-1:0]    act_h_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               frame_rcv_reg;
    logic [1:0]         dr_reg;
    logic [1:0]         dc_reg;
    logic [RGB_W-1:0]   rd_data_reg;
    logic               rd_pend_reg;
    logic [SUM_W-1:0]   acc_b_reg;
    logic [SUM_W-1:0]   acc_g_reg;
    logic [SUM_W-1:0]   acc_r_reg;
    logic [CNT_W-1:0]   acc_cnt_reg;
    logic [PIX_W-1:0]   out_b_reg;
    logic [PIX_W-1:0]   out_g_reg;
    logic [PIX_W-1:0]   out_r_reg;
    logic               out_last_reg;
    logic               out_valid_reg;

    logic               wr_en;
    logic               latch_now;
    logic [FW_W-1:0]    w_eff;
    logic [FH_W-1:0]    h_eff;
    logic [FW_W-1:0]    col_inc;
    logic [FH_W-1:0]    row_inc;
    logic [FH_W-1:0]    o_row_inc;
    logic [FW_W-1:0]    o_col_inc;
    logic [FH_W-1:0]    need_row;
    logic [FW_W-1:0]    need_col;
    logic               pix_ready;
    logic               last_pix;
    logic               row_ok;
    logic               col_ok;
    logic [RING_W-1:0]  rd_row;
    logic [COL_W-1:0]   rd_col;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               out_free;
    chan_num_t          div_num;
    chan_num_t          div_quo;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;

    // input side: store pixel, size latched on the first pixel of a frame
    assign wr_en     = cmd.take && !operation && !frame_rcv_reg;
    assign latch_now = wr_en && (in_row_reg == '0) && (in_col_reg == '0);
    assign w_eff     = latch_now ? clamp_width(fw_cfg_reg) : act_w_reg;
    assign h_eff     = latch_now ? clamp_height(fh_cfg_reg) : act_h_reg;
    assign col_inc   = {1'b0, in_col_reg} + FW_W'(1);
    assign row_inc   = {1'b0, in_row_reg} + FH_W'(1);
    assign wr_addr   = {in_row_reg[RING_W-1:0], in_col_reg};

    // lower-right neighbor of the current output must have arrived
    assign o_row_inc = {1'b0, out_row_reg} + FH_W'(1);
    assign o_col_inc = {1'b0, out_col_reg} + FW_W'(1);
    assign need_row  = (o_row_inc < act_h_reg) ? o_row_inc : act_h_reg - FH_W'(1);
    assign need_col  = (o_col_inc < act_w_reg) ? o_col_inc : act_w_reg - FW_W'(1);
    assign pix_ready = frame_rcv_reg
                    || (need_row < {1'b0, in_row_reg})
                    || ((need_row == {1'b0, in_row_reg}) && (need_col < {1'b0, in_col_reg}));
    assign last_pix  = (o_row_inc == act_h_reg) && (o_col_inc == act_w_reg);

    // neighbor walk, offsets 0..2 stand for -1..+1
    assign row_ok  = !(((dr_reg == 2'd0) && (out_row_reg == '0))
                    || ((dr_reg == 2'd2) && (o_row_inc >= act_h_reg)));
    assign col_ok  = !(((dc_reg == 2'd0) && (out_col_reg == '0))
                    || ((dc_reg == 2'd2) && (o_col_inc >= act_w_reg)));
    assign rd_row  = out_row_reg[RING_W-1:0] + RING_W'(dr_reg) - RING_W'(1);
    assign rd_col  = out_col_reg + COL_W'(dc_reg) - COL_W'(1);
    assign rd_addr = {rd_row, rd_col};

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= {in_red, in_green, in_blue};
        if (cmd.issue)
            rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_cfg_reg    <= FW_RESET;
            fh_cfg_reg    <= FH_RESET;
            act_w_reg     <= FW_RESET;
            act_h_reg     <= FH_RESET;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            frame_rcv_reg <= 1'b0;
            dr_reg        <= '0;
            dc_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fw_cfg_reg <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: fh_cfg_reg <= cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end

            if (latch_now)
            begin
                act_w_reg <= w_eff;
                act_h_reg <= h_eff;
            end

            if (wr_en)
            begin
                if (col_inc >= w_eff)
                begin
                    in_col_reg <= '0;
                    if (row_inc >= h_eff)
                        frame_rcv_reg <= 1'b1;
                    else
                        in_row_reg <= row_inc[ROW_W-1:0];
                end
                else
                begin
                    in_col_reg <= col_inc[COL_W-1:0];
                end
            end

            if (cmd.clr)
            begin
                dr_reg <= '0;
                dc_reg <= '0;
            end
            else if (cmd.issue)
            begin
                if (dc_reg == 2'd2)
                begin
                    dc_reg <= '0;
                    dr_reg <= dr_reg + 2'd1;
                end
                else
                begin
                    dc_reg <= dc_reg + 2'd1;
                end
            end
            rd_pend_reg <= cmd.issue && row_ok && col_ok;

            if (cmd.load)
            begin
                if (o_col_inc == act_w_reg)
                begin
                    out_col_reg <= '0;
                    if (last_pix)
                    begin
                        out_row_reg   <= '0;
                        in_row_reg    <= '0;
                        in_col_reg    <= '0;
                        frame_rcv_reg <= 1'b0;
                    end
                    else
                    begin
                        out_row_reg <= o_row_inc[ROW_W-1:0];
                    end
                end
                else
                begin
                    out_col_reg <= o_col_inc[COL_W-1:0];
                end
            end

            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // sums and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            acc_b_reg   <= '0;
            acc_g_reg   <= '0;
            acc_r_reg   <= '0;
            acc_cnt_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            acc_b_reg   <= acc_b_reg + SUM_W'(rd_data_reg[PIX_W-1:0]);
            acc_g_reg   <= acc_g_reg + SUM_W'(rd_data_reg[2*PIX_W-1:PIX_W]);
            acc_r_reg   <= acc_r_reg + SUM_W'(rd_data_reg[3*PIX_W-1:2*PIX_W]);
            acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
        end

        if (cmd.load)
        begin
            out_b_reg    <= div_quo[0][PIX_W-1:0];
            out_g_reg    <= div_quo[1][PIX_W-1:0];
            out_r_reg    <= div_quo[2][PIX_W-1:0];
            out_last_reg <= last_pix;
        end
    end

    // rounded average: floor((2*sum + count) / (2*count))
    assign div_num[0] = {acc_b_reg, 1'b0} + NUM_W'(acc_cnt_reg);
    assign div_num[1] = {acc_g_reg, 1'b0} + NUM_W'(acc_cnt_reg);
    assign div_num[2] = {acc_r_reg, 1'b0} + NUM_W'(acc_cnt_reg);
    assign div_den    = {acc_cnt_reg, 1'b0};

    boxblur_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign stat.pix_ready = pix_ready;
    assign stat.nb_last   = (dr_reg == 2'd2) && (dc_reg == 2'd2);
    assign stat.div_done  = div_done;
    assign stat.out_free  = out_free;

    assign out_blue   = out_b_reg;
    assign out_green  = out_g_reg;
    assign out_red    = out_r_reg;
    assign frame_last = out_last_reg;
    assign out_valid  = out_valid_reg;

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && last_pix) |=> (!frame_rcv_reg && (in_row_reg == '0)
            && (in_col_reg == '0) && (out_row_reg == '0) && (out_col_reg == '0)))
        else $error("counters not cleared after last pixel of frame");

    a_rcv_col: assert property (@(posedge clk) disable iff (!rst_n)
        frame_rcv_reg |-> (in_col_reg == '0))
        else $error("input column moved after frame complete");

endmodule

// ===== rtl/core/boxblur_ctrl.sv =====
module boxblur_ctrl
    import boxblur_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = stat.pix_ready ? ST_READ : ST_IDLE;
            ST_READ:  if (stat.nb_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_DIVS;
            ST_DIVS:  state_next = ST_DIV;
            ST_DIV:   if (stat.div_done) state_next = ST_LOAD;
            ST_LOAD:  if (stat.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_CHECK: cmd.clr       = stat.pix_ready;
            ST_READ:  cmd.issue     = 1'b1;
            ST_DIVS:  cmd.div_start = 1'b1;
            ST_LOAD:  cmd.load      = stat.out_free;
            default: ;
        endcase
    end

    a_drain_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> $past(stat.nb_last))
        else $error("neighbor walk ended early");

endmodule

// ===== verif/box_blur_3x3_edge_aware_top_tb.sv =====
module box_blur_3x3_edge_aware_top_tb
    import boxblur_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // enough to cover a beat still in flight through the block
    localparam int unsigned SETTLE_CYCLES = 40;
    // no beat moving on either side for this long means the block is hung
    localparam int unsigned STUCK_LIMIT   = 4000;
    // long receiver hold-off so the block backs up into its input
    localparam int unsigned HOLD_CYCLES   = 500;
    localparam int unsigned RANDOM_BEATS  = 900;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } blur_op_t;

    typedef struct packed {
        blur_op_t         op;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } blur_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             last;
    } blur_pixel_t;

    // ports; every input of the block is known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  operation = 1'b0;
    logic [PIX_W-1:0]      in_blue   = '0;
    logic [PIX_W-1:0]      in_green  = '0;
    logic [PIX_W-1:0]      in_red    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      out_blue;
    logic [PIX_W-1:0]      out_green;
    logic [PIX_W-1:0]      out_red;
    logic                  frame_last;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    box_blur_3x3_edge_aware_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .in_blue    (in_blue),
        .in_green   (in_green),
        .in_red     (in_red),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .frame_last (frame_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // blur predictor: four-row ring of pixels, frame counters, sizes
    // ------------------------------------------------------------------
    logic [RGB_W-1:0] pixel_ring [RING_ROWS][MAX_WIDTH] = '{default: '0};
    logic [FW_W-1:0]  shadow_width  = FW_RESET;
    logic [FH_W-1:0]  shadow_height = FH_RESET;
    int unsigned      act_w   = 640;
    int unsigned      act_h   = 480;
    int unsigned      in_row  = 0;
    int unsigned      in_col  = 0;
    int unsigned      out_row = 0;
    int unsigned      out_col = 0;
    bit               frame_full = 1'b0;

    blur_pixel_t blur_expected [$];
    blur_beat_t  pending_beats [$];

    int unsigned beats_queued = 0;
    int unsigned beats_taken  = 0;
    int unsigned mismatches   = 0;
    bit          hold_request = 1'b0;

    // zero reads as one, oversize saturates
    function automatic int unsigned fit_size(int unsigned v, int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    // rounds half up without fractions
    function automatic logic [PIX_W-1:0] blur_mean(int unsigned sum, int unsigned n);
        return PIX_W'((2 * sum + n) / (2 * n));
    endfunction

    // apply one accepted beat; push the output pixel it releases, if any
    function automatic void blur_advance(blur_beat_t b);
        int unsigned nr;
        int unsigned nc;
        int unsigned need;
        int unsigned have;
        int unsigned n;
        int unsigned sum_b;
        int unsigned sum_g;
        int unsigned sum_r;
        int          rr;
        int          cc;
        logic [RGB_W-1:0] px;
        blur_pixel_t res;

        // store the pixel unless the frame is already complete
        if (b.op == OP_PIXEL && !frame_full)
        begin
            if (in_row == 0 && in_col == 0)
            begin
                act_w = fit_size(shadow_width, MAX_WIDTH);
                act_h = fit_size(shadow_height, MAX_HEIGHT);
            end
            pixel_ring[in_row % RING_ROWS][in_col] = {b.red, b.green, b.blue};
            in_col++;
            if (in_col >= act_w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= act_h)
                    frame_full = 1'b1;
            end
        end

        // next output goes once its lower-right neighbor has arrived
        nr   = (out_row + 1 < act_h) ? out_row + 1 : act_h - 1;
        nc   = (out_col + 1 < act_w) ? out_col + 1 : act_w - 1;
        need = nr * act_w + nc;
        have = frame_full ? act_w * act_h : in_row * act_w + in_col;
        if (need >= have)
            return;

        n     = 0;
        sum_b = 0;
        sum_g = 0;
        sum_r = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = int'(out_row) + dr;
                cc = int'(out_col) + dc;
                // neighbors off the frame are skipped
                if (rr < 0 || cc < 0 || rr >= int'(act_h) || cc >= int'(act_w))
                    continue;
                px     = pixel_ring[rr % RING_ROWS][cc];
                sum_b += px[PIX_W-1:0];
                sum_g += px[2*PIX_W-1:PIX_W];
                sum_r += px[3*PIX_W-1:2*PIX_W];
                n++;
            end
        end

        res.blue  = blur_mean(sum_b, n);
        res.green = blur_mean(sum_g, n);
        res.red   = blur_mean(sum_r, n);
        res.last  = 1'b0;

        out_col++;
        if (out_col >= act_w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= act_h)
            begin
                // frame done, the next pixel opens a new one
                res.last   = 1'b1;
                out_row    = 0;
                in_row     = 0;
                in_col     = 0;
                frame_full = 1'b0;
            end
        end
        blur_expected.push_back(res);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // input driver: offers queued beats, predicts each accepted one
    // ------------------------------------------------------------------
    blur_beat_t  offered;
    bit          in_fire;
    bit          steady_in = 1'b0;
    int unsigned in_gap    = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= OP_PIXEL;
            in_blue   <= '0;
            in_green  <= '0;
            in_red    <= '0;
            in_gap     = 0;
        end
        else
        begin
            in_fire = in_valid && in_ready;
            if (in_fire)
            begin
                blur_advance(offered);
                beats_taken++;
            end
            // payload only moves once the current beat is gone
            if (!in_valid || in_fire)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    offered    = pending_beats.pop_front();
                    in_valid  <= 1'b1;
                    operation <= offered.op;
                    in_blue   <= offered.blue;
                    in_green  <= offered.green;
                    in_red    <= offered.red;
                    in_gap     = pick_gap(steady_in);
                    // switch between gappy and back-to-back stretches
                    if ($urandom_range(49) == 0)
                        steady_in = !steady_in;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: random back-pressure, checks every output beat
    // ------------------------------------------------------------------
    blur_pixel_t want;
    bit          out_fire;
    bit          next_ready;
    bit          steady_out = 1'b0;
    bit          hold_done  = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            out_fire = out_valid && out_ready;
            if (out_fire)
            begin
                if (blur_expected.size() == 0)
                begin
                    $error("output beat with nothing expected: b=%0d g=%0d r=%0d last=%0b",
                           out_blue, out_green, out_red, frame_last);
                    mismatches++;
                end
                else
                begin
                    want = blur_expected.pop_front();
                    if (out_blue !== want.blue)
                    begin
                        $error("out_blue expected %0d actual %0d", want.blue, out_blue);
                        mismatches++;
                    end
                    if (out_green !== want.green)
                    begin
                        $error("out_green expected %0d actual %0d", want.green, out_green);
                        mismatches++;
                    end
                    if (out_red !== want.red)
                    begin
                        $error("out_red expected %0d actual %0d", want.red, out_red);
                        mismatches++;
                    end
                    if (frame_last !== want.last)
                    begin
                        $error("frame_last expected %0b actual %0b", want.last, frame_last);
                        mismatches++;
                    end
                end
            end

            // one long hold-off, requested by the stimulus while beats keep coming
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                if (!steady_out && $urandom_range(3) == 0)
                    stall_left = pick_gap(1'b0);
            end
            if ($urandom_range(199) == 0)
                steady_out = !steady_out;
            out_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles with no beat on either side
    // ------------------------------------------------------------------
    int unsigned stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[box_blur_3x3_edge_aware_top] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(blur_op_t op, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] r);
        blur_beat_t beat;
        beat.op    = op;
        beat.blue  = b;
        beat.green = g;
        beat.red   = r;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic wait_taken();
        wait (beats_taken == beats_queued);
    endtask

    // sender pauses until every output is back and the block has settled
    task automatic wait_quiet();
        wait_taken();
        wait (blur_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_FRAME_WIDTH)
            shadow_width = data[FW_W-1:0];
        else
            shadow_height = data[FH_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        wait_quiet();
        if ($urandom_range(1) == 0)
        begin
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        end
        else
        begin
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        end
    endtask

    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 70)
            return $urandom_range(1, 5);
        if (r < 92)
            return $urandom_range(6, 16);
        return $urandom_range(17, 40);
    endfunction

    function automatic int unsigned pick_height();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 75)
            return $urandom_range(1, 5);
        return $urandom_range(6, 10);
    endfunction

    // channel level: full range, hard extremes, or near the extremes
    function automatic logic [PIX_W-1:0] pick_level(int unsigned style);
        case (style)
            2: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            3: return ($urandom_range(1) != 0) ? PIX_W'($urandom_range(252, 255))
                                               : PIX_W'($urandom_range(0, 3));
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_noise_drain();
        queue_beat(OP_DRAIN, pick_level(0), pick_level(0), pick_level(0));
    endtask

    // after the last pixel: push exactly the beats that release the rest of the frame,
    // some as pixels the block ignores, then up to two drains that find nothing
    task automatic flush_frame();
        int unsigned left;
        int unsigned extra;
        wait_taken();
        left = frame_full ? act_w * act_h - (out_row * act_w + out_col) : 0;
        repeat (left)
        begin
            if ($urandom_range(3) == 0)
                queue_beat(OP_PIXEL, pick_level(0), pick_level(0), pick_level(0));
            else
                queue_noise_drain();
        end
        extra = $urandom_range(2);
        repeat (extra) queue_noise_drain();
    endtask

    // one whole frame at the current register values
    task automatic run_frame(bit allow_mid_write);
        int unsigned total;
        int unsigned split;
        int unsigned style;
        total = fit_size(shadow_width, MAX_WIDTH) * fit_size(shadow_height, MAX_HEIGHT);
        style = $urandom_range(3);
        split = total;
        // a register change partway through only counts for the next frame
        if (allow_mid_write && total > 1 && $urandom_range(4) == 0)
            split = $urandom_range(1, total - 1);
        for (int unsigned i = 0; i < total; i++)
        begin
            if (i == split)
            begin
                wait_quiet();
                write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(pick_width()));
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(pick_height()));
            end
            if ($urandom_range(9) == 0)
                queue_noise_drain();
            queue_beat(OP_PIXEL, pick_level(style), pick_level(style), pick_level(style));
        end
        flush_frame();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned random_start;
        int unsigned frames;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 3x3 frame, corners/edges/center, extreme levels
        set_size(3, 3);
        queue_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00);     // drain with nothing ready
        queue_beat(OP_PIXEL, 8'h00, 8'h00, 8'h00);
        queue_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        queue_beat(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
        queue_beat(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);

        // register write mid-frame: 3x3 stays latched, next frame is 1x1
        wait_quiet();
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);

        queue_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);     // first output now ready
        queue_beat(OP_DRAIN, 8'hAA, 8'h55, 8'hAA);     // drain before frame complete
        queue_beat(OP_PIXEL, 8'h01, 8'h80, 8'hFE);
        queue_beat(OP_PIXEL, 8'hFF, 8'h00, 8'h00);
        queue_beat(OP_PIXEL, 8'h00, 8'h00, 8'hFF);
        queue_beat(OP_PIXEL, 8'h7F, 8'hFF, 8'h80);     // last pixel, frame complete
        queue_beat(OP_PIXEL, 8'h12, 8'h34, 8'h56);     // pixel after frame complete
        flush_frame();

        // 1x1 frames: every pixel is its own frame
        queue_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        queue_beat(OP_PIXEL, 8'h00, 8'h01, 8'h02);
        queue_beat(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        flush_frame();

        // random frames, mostly small
        random_start = beats_queued;
        frames       = 0;
        while (beats_queued - random_start < RANDOM_BEATS)
        begin
            if (frames == 3)
            begin
                // receiver holds off while this frame keeps the input busy
                set_size(8, 6);
                hold_request = 1'b1;
            end
            else if ($urandom_range(2) == 0)
            begin
                set_size(pick_width(), pick_height());
            end
            else if ($urandom_range(7) == 0)
            begin
                wait_quiet();
            end
            run_frame(1'b1);
            frames++;
        end

        // drain out, then settle for the block latency
        wait_quiet();
        if (mismatches == 0 && blur_expected.size() == 0)
            $display("[box_blur_3x3_edge_aware_top] OK");
        else
            $display("[box_blur_3x3_edge_aware_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/boxblur_pkg.sv
rtl/core/boxblur_div.sv
rtl/core/boxblur_dp.sv
rtl/core/boxblur_ctrl.sv
rtl/core/box_blur_3x3_edge_aware_top.sv
verif/box_blur_3x3_edge_aware_top_tb.sv
